FILE: rtl/core/pp_pkg.sv
// shared types and constants for the polygon perimeter block
// depends on nothing; used by polygon_perimeter and pp_isqrt
package pp_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int SUM_WIDTH   = 40;

	// magnitude of a coordinate difference, its square, radicand and root
	localparam int DIFF_W = COORD_WIDTH;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int ROOT_W = DIFF_W + 1;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int ADD_W  = ((SUM_WIDTH > ROOT_W) ? SUM_WIDTH : ROOT_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_WAIT,
		ST_EMIT
	} pp_state_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] vertex_x;
		logic signed [COORD_WIDTH-1:0] vertex_y;
		logic                          last_vertex;
	} vertex_t;

	typedef struct packed {
		logic [SUM_WIDTH-1:0] perimeter;
		logic                 saturated;
	} result_t;

endpackage

FILE: rtl/core/pp_isqrt.sv
// iterative integer square root, one root bit per cycle
// depends on pp_pkg for the default root width
module pp_isqrt #(
	parameter int ROOT_W = pp_pkg::ROOT_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   radicand,
	output logic                  done,
	output logic [ROOT_W-1:0]     root
);

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [1:0]        pair;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              ge;
	logic [REM_W-1:0]  rem_nx;
	logic [ROOT_W-1:0] root_nx;

	always_comb begin
		pair    = rad_q[RAD_W-1 -: 2];
		rem_sh  = {rem_q[REM_W-3:0], pair};
		trial   = {root_q, 2'b01};
		ge      = (rem_sh >= trial);
		rem_nx  = ge ? (rem_sh - trial) : rem_sh;
		root_nx = {root_q[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= rem_nx;
			root_q <= root_nx;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/core/polygon_perimeter.sv
// polygon perimeter: sums euclidean edge lengths of a vertex stream
// vertex channel in, result channel out (valid/ready, one transfer per item)
// each vertex is a signed q.8 point; last_vertex closes the polygon
// a result transfer follows only a last vertex: perimeter in unsigned q.8,
// clamped at all ones, with saturated set if any addition was clamped
// every edge goes through the difference, two squares on one shared
// multiplier, and the iterative square root unit, one root bit per cycle
// a middle vertex works one edge; a later last vertex works two, from the
// previous vertex and back to the first, before its result; a first vertex
// that is not last is only stored
// vertex_ready is high only while idle; one item is worked on at a time
// the result sits in an output register, so the next polygon's vertices are
// taken while it waits; a further result waits until that register is free
// reset clears the running sum, the first-vertex flag and the output valid
// a single-vertex polygon gives perimeter 0
module polygon_perimeter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vertex_valid,
	output logic              vertex_ready,
	input  pp_pkg::vertex_t   vertex,
	output logic              result_valid,
	input  logic              result_ready,
	output pp_pkg::result_t   result
);

	import pp_pkg::*;

	pp_state_t state_q, state_d;

	logic signed [COORD_WIDTH-1:0] first_x_q, first_y_q;
	logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_WIDTH-1:0] cur_x_q, cur_y_q;
	logic                          last_q;
	logic                          have_first_q;
	logic                          edge_sel_q;
	logic [SUM_WIDTH-1:0]          sum_q;
	logic                          ovf_q;
	logic [DIFF_W-1:0]             dx_q, dy_q;
	logic [SQ_W-1:0]               acc_q, mul_q;
	logic                          out_valid_q;
	result_t                       out_q;

	logic                          take;
	logic                          emit;
	logic                          sq_start;
	logic                          sq_done;
	logic [ROOT_W-1:0]             sq_root;
	logic [RAD_W-1:0]              radicand;

	logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
	logic signed [COORD_WIDTH:0]   dxs, dys;
	logic [DIFF_W-1:0]             dx_mag, dy_mag;
	logic [DIFF_W-1:0]             mul_op;
	logic [SQ_W-1:0]               product;
	logic [ADD_W-1:0]              total;
	logic                          total_sat;

	// edge endpoints: previous to current, or current back to first
	always_comb begin
		ax  = edge_sel_q ? cur_x_q : prev_x_q;
		ay  = edge_sel_q ? cur_y_q : prev_y_q;
		bx  = edge_sel_q ? first_x_q : cur_x_q;
		by  = edge_sel_q ? first_y_q : cur_y_q;
		dxs = {ax[COORD_WIDTH-1], ax} - {bx[COORD_WIDTH-1], bx};
		dys = {ay[COORD_WIDTH-1], ay} - {by[COORD_WIDTH-1], by};
		dx_mag = dxs[COORD_WIDTH] ? DIFF_W'(-dxs) : DIFF_W'(dxs);
		dy_mag = dys[COORD_WIDTH] ? DIFF_W'(-dys) : DIFF_W'(dys);
	end

	// shared multiplier
	assign mul_op   = (state_q == ST_SQX) ? dx_q : dy_q;
	assign product  = SQ_W'(mul_op * mul_op);
	assign radicand = RAD_W'(acc_q) + RAD_W'(mul_q);

	// saturating accumulate
	assign total     = ADD_W'(sum_q) + ADD_W'(sq_root);
	assign total_sat = |total[ADD_W-1:SUM_WIDTH];

	pp_isqrt #(
		.ROOT_W(ROOT_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(radicand),
		.done    (sq_done),
		.root    (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		vertex_ready = 1'b0;
		take         = 1'b0;
		sq_start     = 1'b0;
		emit         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				vertex_ready = 1'b1;
				take         = vertex_valid;
				if (vertex_valid) begin
					if (have_first_q || vertex.last_vertex) begin
						state_d = ST_DIFF;
					end
				end
			end
			ST_DIFF: begin
				state_d = ST_SQX;
			end
			ST_SQX: begin
				state_d = ST_SQY;
			end
			ST_SQY: begin
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				sq_start = 1'b1;
				state_d  = ST_WAIT;
			end
			ST_WAIT: begin
				if (sq_done) begin
					if (last_q && !edge_sel_q) begin
						state_d = ST_DIFF;
					end else if (last_q) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || result_ready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
			edge_sel_q   <= 1'b0;
			last_q       <= 1'b0;
			sum_q        <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				last_q <= vertex.last_vertex;
				if (!have_first_q) begin
					have_first_q <= 1'b1;
					sum_q        <= '0;
					ovf_q        <= 1'b0;
					edge_sel_q   <= 1'b1;
				end else begin
					edge_sel_q <= 1'b0;
				end
			end
			if (state_q == ST_WAIT && sq_done) begin
				edge_sel_q <= 1'b1;
				if (total_sat) begin
					sum_q <= '1;
					ovf_q <= 1'b1;
				end else begin
					sum_q <= SUM_WIDTH'(total);
				end
			end
			if (emit) begin
				have_first_q <= 1'b0;
				sum_q        <= '0;
				ovf_q        <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_x_q <= vertex.vertex_x;
			cur_y_q <= vertex.vertex_y;
			if (!have_first_q) begin
				first_x_q <= vertex.vertex_x;
				first_y_q <= vertex.vertex_y;
				prev_x_q  <= vertex.vertex_x;
				prev_y_q  <= vertex.vertex_y;
			end
		end
		if (state_q == ST_DIFF) begin
			dx_q <= dx_mag;
			dy_q <= dy_mag;
			if (!edge_sel_q) begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
			end
		end
		if (state_q == ST_SQX) begin
			acc_q <= product;
		end
		if (state_q == ST_SQY) begin
			mul_q <= product;
		end
		if (emit) begin
			out_q.perimeter <= sum_q;
			out_q.saturated <= ovf_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |-> &result.perimeter)
		else $error("saturated result with perimeter below maximum");

	a_first_kept: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && vertex_ready |=> have_first_q)
		else $error("vertex transfer left no first vertex");

	a_root_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_WAIT)
		else $error("square root finished outside wait state");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !result_valid || result_ready)
		else $error("result overwritten while stalled");
`endif

endmodule
